// ===== rtl/bsa_pkg.sv =====
// Shared types and constants of the bitmap slice allocator.
package bsa_pkg;

    localparam int BSA_MAX_SLOTS = 64;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CNT_W       = 7;
    localparam int OUT_IDX_W   = 6;
    localparam int BYTES_W     = 16;
    localparam int ADDR_W      = 32;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_SCAN  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NONE  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR   = 2'd2;

    localparam logic [CNT_W-1:0]   RST_SLICE_COUNT = 7'd64;
    localparam logic [BYTES_W-1:0] RST_SLICE_BYTES = 16'd64;
    localparam logic [ADDR_W-1:0]  RST_BASE_ADDR   = 32'd0;

    typedef struct packed {
        logic capture;
        logic find;
        logic div_step;
        logic mul;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       bytes_zero;
        logic       div_last;
        logic       out_free;
    } t_dp_sts;

endpackage

// ===== rtl/bsa_ctrl.sv =====
// Sequencing state machine of the bitmap slice allocator.
module bsa_ctrl
    import bsa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_FIND   = 5'b00010,
        S_DIV    = 5'b00100,
        S_MUL    = 5'b01000,
        S_COMMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_FIND;
                end
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                if (i_sts.cmd == CMD_FREE && !i_sts.bytes_zero) begin
                    n_state = S_DIV;
                end else if (i_sts.cmd == CMD_ALLOC || i_sts.cmd == CMD_SCAN) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/bsa_dp.sv =====
// Datapath of the bitmap slice allocator: bitmap, counts, encoder, divider, address.
module bsa_dp
    import bsa_pkg::*;
#(
    parameter int MAX_SLOTS = BSA_MAX_SLOTS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0] o_out_data,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts
);

    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int STEP_W = $clog2(IDX_W + 1);
    localparam int DIV_W  = BYTES_W + IDX_W;
    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_SLOTS);

    // configuration
    logic [CNT_W-1:0]   r_slice_count;
    logic [BYTES_W-1:0] r_slice_bytes;
    logic [ADDR_W-1:0]  r_base_addr;

    // state
    logic [MAX_SLOTS-1:0] r_use_map;
    logic [CNT_W-1:0]     r_act_cnt;

    // transaction in flight
    logic [1:0]        r_cmd;
    logic [ADDR_W-1:0] r_faddr;
    logic [CNT_W-1:0]  r_start;
    logic [IDX_W-1:0]  r_idx;
    logic              r_found;
    logic [ADDR_W-1:0] r_rem;
    logic              r_inrange;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_prod;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [CNT_W-1:0]     eff_n;
    logic [MAX_SLOTS-1:0] lane_mask;
    logic [MAX_SLOTS-1:0] lane_ge;
    logic [MAX_SLOTS-1:0] pe_vec;
    logic [IDX_W-1:0]     pe_idx;
    logic                 pe_any;
    logic [ADDR_W-1:0]    diff;
    logic [DIV_W-1:0]     div_d;
    logic                 div_ge;
    logic [STEP_W-1:0]    shamt;
    logic                 range_err;
    logic                 found_c;
    logic [1:0]           status_c;
    logic [IDX_W-1:0]     idx_c;
    logic [ADDR_W-1:0]    addr_c;
    logic [CNT_W-1:0]     npos_c;
    logic [CNT_W-1:0]     act_c;
    logic [CNT_W-1:0]     avail_c;

    assign eff_n = (r_slice_count > MAX_N) ? MAX_N : r_slice_count;
    assign diff  = r_faddr - r_base_addr;

    always_comb begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            lane_mask[i] = CNT_W'(i) < eff_n;
            lane_ge[i]   = CNT_W'(i) >= r_start;
        end
    end

    always_comb begin
        unique case (r_cmd)
            CMD_ALLOC: pe_vec = ~r_use_map & lane_mask;
            CMD_FREE:  pe_vec = r_use_map & lane_mask;
            CMD_SCAN:  pe_vec = r_use_map & lane_mask & lane_ge;
            default:   pe_vec = '0;
        endcase
    end

    // lowest set bit
    always_comb begin
        pe_idx = '0;
        pe_any = 1'b0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (pe_vec[i]) begin
                pe_idx = IDX_W'(i);
                pe_any = 1'b1;
            end
        end
    end

    // restoring division of the address offset by the slice size
    assign shamt  = STEP_W'(IDX_W - 1) - r_step;
    assign div_d  = DIV_W'(r_slice_bytes) << shamt;
    assign div_ge = r_rem >= ADDR_W'(div_d);

    assign range_err = (r_cmd == CMD_SCAN) && (r_start >= eff_n);

    always_comb begin
        unique case (r_cmd)
            CMD_ALLOC, CMD_SCAN: found_c = r_found;
            CMD_FREE: begin
                if (r_slice_bytes == '0) begin
                    found_c = r_found;
                end else begin
                    found_c = r_inrange && (r_rem == '0) && (CNT_W'(r_idx) < eff_n)
                              && r_use_map[r_idx];
                end
            end
            default: found_c = 1'b0;
        endcase
    end

    always_comb begin
        act_c = r_act_cnt;
        if (found_c && r_cmd == CMD_ALLOC) begin
            act_c = r_act_cnt + CNT_W'(1);
        end else if (found_c && r_cmd == CMD_FREE) begin
            act_c = r_act_cnt - CNT_W'(1);
        end
    end

    always_comb begin
        if (range_err) begin
            status_c = STATUS_RANGE;
        end else if (found_c) begin
            status_c = STATUS_OK;
        end else begin
            status_c = STATUS_NONE;
        end
    end

    assign idx_c   = found_c ? r_idx : '0;
    assign addr_c  = !found_c ? '0 :
                     (r_cmd == CMD_FREE) ? r_faddr : r_base_addr + ADDR_W'(r_prod);
    assign npos_c  = (r_cmd == CMD_SCAN && !range_err) ?
                     (found_c ? CNT_W'(r_idx) + CNT_W'(1) : '0) : r_start;
    assign avail_c = (eff_n > act_c) ? eff_n - act_c : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_count <= RST_SLICE_COUNT;
            r_slice_bytes <= RST_SLICE_BYTES;
            r_base_addr   <= RST_BASE_ADDR;
        end else if (i_cfg_we) begin
            priority case (i_cfg_idx)
                CFG_SLICE_COUNT: r_slice_count <= i_cfg_data[CNT_W-1:0];
                CFG_SLICE_BYTES: r_slice_bytes <= i_cfg_data[BYTES_W-1:0];
                CFG_BASE_ADDR:   r_base_addr   <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_map   <= '0;
            r_act_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_act_cnt   <= act_c;
                r_out_valid <= 1'b1;
                if (found_c && r_cmd == CMD_ALLOC) begin
                    r_use_map[r_idx] <= 1'b1;
                end else if (found_c && r_cmd == CMD_FREE) begin
                    r_use_map[r_idx] <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_in_data[1:0];
            r_faddr <= i_in_data[33:2];
            r_start <= i_in_data[40:34];
        end
        if (i_cmd.find) begin
            r_idx     <= pe_idx;
            r_found   <= pe_any && !(r_cmd == CMD_FREE && diff != '0);
            r_rem     <= diff;
            r_inrange <= diff < ADDR_W'(DIV_W'(r_slice_bytes) << IDX_W);
            r_step    <= '0;
        end
        if (i_cmd.div_step) begin
            if (div_ge) begin
                r_rem <= r_rem - ADDR_W'(div_d);
            end
            r_idx  <= IDX_W'({r_idx, div_ge});
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.mul) begin
            r_prod <= DIV_W'(r_slice_bytes) * DIV_W'(r_idx);
        end
        if (i_cmd.commit) begin
            r_out_data <= {3'b000, avail_c, act_c, npos_c, addr_c,
                           OUT_IDX_W'(idx_c), status_c};
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;
    assign o_sts.cmd        = r_cmd;
    assign o_sts.bytes_zero = (r_slice_bytes == '0);
    assign o_sts.div_last   = (r_step == STEP_W'(IDX_W - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    a_count_matches_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act_cnt == CNT_W'($countones(r_use_map)))
        else $error("active count differs from bitmap population");

    a_commit_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_alloc_sets_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_cmd == CMD_ALLOC && found_c) |=> r_use_map[$past(r_idx)])
        else $error("allocated slot not marked in use");

endmodule

// ===== rtl/bitmap_slice_allocator_top.sv =====
// Top level of the bitmap slice allocator: controller plus datapath.
//
// Requests enter on the s_axis channel, one command per transaction
// (allocate, free by address, find next active). Each request gives exactly
// one result on the m_axis channel with status, slot index, slot address,
// next scan position and the active and available counts.
// Configuration (slice count, slice size, base address) is written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only while no
// request is in flight, as the block does not enforce this. One request is
// processed at a time. Allocate and scan run a lowest-bit encode, one multiply
// and a commit; a free with nonzero slice size runs a restoring divide of the
// address offset, one quotient bit per cycle, before its commit; a free with
// zero slice size or an undefined command goes from encode straight to commit.
// The result turns valid in the same cycle as the next accept is possible.
// Results sit in an output register, so a finished result can wait while
// the block takes the next request; if the receiver stalls with a result
// still held, the following request waits at its commit step.
// Reset (synchronous, active low) clears the bitmap and the active count
// and restores slice count 64, slice size 64 and base address 0.
module bitmap_slice_allocator_top
    import bsa_pkg::*;
#(
    parameter int MAX_SLOTS = BSA_MAX_SLOTS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // cmd[1:0], free_addr[33:2], start_pos[40:34], zero pad[47:41]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // status[1:0], slot_index[7:2], slot_addr[39:8], next_pos[46:40],
    // active_count[53:47], avail_count[60:54], zero pad[63:61]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    bsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    bsa_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts)
    );

endmodule

// ===== test/bitmap_slice_allocator_top_tb.sv =====
// Self-checking testbench of the bitmap slice allocator: directed plan, then random traffic.
module bitmap_slice_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsa_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0]  start_pos;
        logic [ADDR_W-1:0] free_addr;
        logic [1:0]        cmd;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0]     avail_count;
        logic [CNT_W-1:0]     active_count;
        logic [CNT_W-1:0]     next_pos;
        logic [ADDR_W-1:0]    slot_addr;
        logic [OUT_IDX_W-1:0] slot_index;
        logic [1:0]           status;
    } rsp_t;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_data;
        logic                  typed;
        req_t                  req;
        rsp_t                  rsp;
    } plan_row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    bitmap_slice_allocator_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // pool model state and register copies
    logic [63:0]        use_map    = '0;
    logic [CNT_W-1:0]   used_total = '0;
    logic [CNT_W-1:0]   cfg_count  = RST_SLICE_COUNT;
    logic [BYTES_W-1:0] cfg_bytes  = RST_SLICE_BYTES;
    logic [ADDR_W-1:0]  cfg_base   = RST_BASE_ADDR;

    rsp_t      results_due[$];
    plan_row_t plan[$];

    int snd_idle     = 26;
    int rcv_idle     = 88;
    int mismatches   = 0;
    int results_seen = 0;
    int alloc_reqs   = 0;
    int free_reqs    = 0;
    int scan_reqs    = 0;
    int odd_reqs     = 0;
    int reg_writes   = 0;

    function automatic logic [ADDR_W-1:0] slice_addr(int j);
        return cfg_base + cfg_bytes * 32'(j);
    endfunction

    function automatic int pool_slots();
        return (cfg_count > 7'd64) ? 64 : int'(cfg_count);
    endfunction

    function automatic rsp_t pool_step(req_t r);
        rsp_t o;
        int   n;
        int   i;
        bit   hit;
        n          = pool_slots();
        o          = '0;
        o.status   = STATUS_NONE;
        o.next_pos = r.start_pos;
        hit        = 1'b0;
        if (r.cmd == CMD_ALLOC) begin
            for (i = 0; i < n && !hit; i++) begin
                if (!use_map[i]) begin
                    use_map[i]   = 1'b1;
                    used_total   = used_total + 7'd1;
                    o.status     = STATUS_OK;
                    o.slot_index = OUT_IDX_W'(i);
                    o.slot_addr  = slice_addr(i);
                    hit          = 1'b1;
                end
            end
        end else if (r.cmd == CMD_FREE) begin
            for (i = 0; i < n && !hit; i++) begin
                if (use_map[i] && slice_addr(i) == r.free_addr) begin
                    use_map[i]   = 1'b0;
                    used_total   = used_total - 7'd1;
                    o.status     = STATUS_OK;
                    o.slot_index = OUT_IDX_W'(i);
                    o.slot_addr  = r.free_addr;
                    hit          = 1'b1;
                end
            end
        end else if (r.cmd == CMD_SCAN) begin
            if (int'(r.start_pos) >= n) begin
                o.status = STATUS_RANGE;
            end else begin
                o.next_pos = '0;
                for (i = int'(r.start_pos); i < n && !hit; i++) begin
                    if (use_map[i]) begin
                        o.status     = STATUS_OK;
                        o.slot_index = OUT_IDX_W'(i);
                        o.slot_addr  = slice_addr(i);
                        o.next_pos   = CNT_W'(i + 1);
                        hit          = 1'b1;
                    end
                end
            end
        end
        o.active_count = used_total;
        o.avail_count  = (n > int'(used_total)) ? CNT_W'(n - int'(used_total)) : '0;
        return o;
    endfunction

    function automatic rsp_t want_rsp(logic [1:0] status, int idx, logic [31:0] addr,
                                      int npos, int act, int avail);
        return {CNT_W'(avail), CNT_W'(act), CNT_W'(npos), addr, OUT_IDX_W'(idx), status};
    endfunction

    function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row          = '0;
        row.is_cfg   = 1'b1;
        row.cfg_idx  = idx;
        row.cfg_data = data;
        plan.push_back(row);
    endfunction

    function automatic void plan_item(int typed, logic [1:0] cmd, logic [31:0] addr,
                                      int start, rsp_t want);
        plan_row_t row;
        row               = '0;
        row.typed         = (typed != 0);
        row.req.cmd       = cmd;
        row.req.free_addr = addr;
        row.req.start_pos = CNT_W'(start);
        row.rsp           = want;
        plan.push_back(row);
    endfunction

    task automatic report(string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("ERROR: %s", msg);
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                             results_seen, name, got, want));
    endtask

    task automatic check_result(rsp_t got);
        rsp_t want;
        results_seen++;
        if (results_due.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
            want = results_due.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("slot_index", got.slot_index, want.slot_index);
            compare_field("slot_addr", got.slot_addr, want.slot_addr);
            compare_field("next_pos", got.next_pos, want.next_pos);
            compare_field("active_count", got.active_count, want.active_count);
            compare_field("avail_count", got.avail_count, want.avail_count);
        end
    endtask

    task automatic send_req(req_t r, logic typed, rsp_t typed_rsp);
        rsp_t want;
        while ($urandom_range(99) < snd_idle) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_TDATA_W'(r);
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        want = pool_step(r);
        results_due.push_back(typed ? typed_rsp : want);
        case (r.cmd)
            CMD_ALLOC: alloc_reqs++;
            CMD_FREE:  free_reqs++;
            CMD_SCAN:  scan_reqs++;
            default:   odd_reqs++;
        endcase
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_SLICE_COUNT: cfg_count = data[CNT_W-1:0];
            CFG_SLICE_BYTES: cfg_bytes = data[BYTES_W-1:0];
            CFG_BASE_ADDR:   cfg_base  = data[ADDR_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side: random backpressure, one check per accepted transaction
    initial begin
        rsp_t got;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
                got = o_m_axis_tdata[$bits(rsp_t)-1:0];
                check_result(got);
            end
            i_m_axis_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    initial begin
        plan_row_t row;
        req_t      r;
        int        mode;
        int        setting;
        int        k;
        int        j;
        int        lim;
        int        n;
        int        pick;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pool, range errors, undefined command, first allocations, scans and frees
        plan_item(1, CMD_SCAN, 32'h0, 0, want_rsp(STATUS_NONE, 0, 32'h0, 0, 0, 64));
        plan_item(1, CMD_FREE, 32'h0, 0, want_rsp(STATUS_NONE, 0, 32'h0, 0, 0, 64));
        plan_item(1, CMD_SCAN, 32'h0, 64, want_rsp(STATUS_RANGE, 0, 32'h0, 64, 0, 64));
        plan_item(1, CMD_SCAN, 32'h0, 127, want_rsp(STATUS_RANGE, 0, 32'h0, 127, 0, 64));
        plan_item(1, CMD_UNUSED, 32'hFFFF_FFFF, 5,
                  want_rsp(STATUS_NONE, 0, 32'h0, 5, 0, 64));
        plan_item(1, CMD_ALLOC, 32'h0, 0, want_rsp(STATUS_OK, 0, 32'h0, 0, 1, 63));
        plan_item(1, CMD_ALLOC, 32'h0, 0, want_rsp(STATUS_OK, 1, 32'd64, 0, 2, 62));
        plan_item(0, CMD_SCAN, 32'h0, 0, '0);
        plan_item(0, CMD_SCAN, 32'h0, 1, '0);
        plan_item(0, CMD_SCAN, 32'h0, 2, '0);
        plan_item(0, CMD_FREE, 32'h0, 0, '0);
        plan_item(1, CMD_FREE, 32'hFFFF_FFFF, 0, want_rsp(STATUS_NONE, 0, 32'h0, 0, 1, 63));
        // address wrap with largest slice
        plan_cfg(CFG_BASE_ADDR, 32'hFFFF_FFFF);
        plan_cfg(CFG_SLICE_BYTES, 32'd65535);
        plan_item(0, CMD_ALLOC, 32'h0, 0, '0);
        plan_item(0, CMD_ALLOC, 32'h0, 0, '0);
        plan_item(0, CMD_FREE, 32'h0000_FFFE, 0, '0);
        // zero slice size: every slot sits at the base
        plan_cfg(CFG_SLICE_BYTES, 32'd0);
        plan_item(0, CMD_FREE, 32'hFFFF_FFFF, 0, '0);
        plan_item(0, CMD_ALLOC, 32'h0, 0, '0);
        // pool shrunk below the used slots
        plan_cfg(CFG_SLICE_COUNT, 32'd1);
        plan_item(1, CMD_ALLOC, 32'h0, 0, want_rsp(STATUS_NONE, 0, 32'h0, 0, 2, 0));
        plan_item(1, CMD_SCAN, 32'h0, 1, want_rsp(STATUS_RANGE, 0, 32'h0, 1, 2, 0));
        plan_item(0, CMD_SCAN, 32'h0, 0, '0);
        // empty pool
        plan_cfg(CFG_SLICE_COUNT, 32'd0);
        plan_item(1, CMD_ALLOC, 32'h0, 0, want_rsp(STATUS_NONE, 0, 32'h0, 0, 2, 0));
        plan_item(1, CMD_SCAN, 32'h0, 0, want_rsp(STATUS_RANGE, 0, 32'h0, 0, 2, 0));
        plan_item(1, CMD_FREE, 32'hFFFF_FFFF, 0, want_rsp(STATUS_NONE, 0, 32'h0, 0, 2, 0));
        // count above the slot limit saturates
        plan_cfg(CFG_SLICE_COUNT, 32'd127);
        plan_cfg(CFG_SLICE_BYTES, 32'd1);
        plan_cfg(CFG_BASE_ADDR, 32'd0);
        plan_item(0, CMD_SCAN, 32'h0, 63, '0);
        plan_item(0, CMD_ALLOC, 32'h0, 0, '0);

        while (plan.size() != 0) begin
            row = plan.pop_front();
            if (row.is_cfg)
                write_reg(row.cfg_idx, row.cfg_data);
            else
                send_req(row.req, row.typed, row.rsp);
        end

        for (mode = 0; mode < 3; mode++) begin
            snd_idle = (mode == 0) ? 26 : (mode == 1) ? 88 : 0;
            rcv_idle = (mode == 0) ? 88 : (mode == 1) ? 26 : 0;
            for (setting = 0; setting < 3; setting++) begin
                pick = $urandom_range(11);
                write_reg(CFG_SLICE_COUNT, (pick == 0) ? 0 : (pick == 1) ? 1 :
                                           (pick == 2) ? 64 :
                                           (pick == 3) ? $urandom_range(127, 65) :
                                           $urandom_range(64, 2));
                pick = $urandom_range(7);
                write_reg(CFG_SLICE_BYTES, (pick == 0) ? 0 : (pick == 1) ? 1 :
                                           (pick == 2) ? 65535 : $urandom_range(65535, 2));
                pick = $urandom_range(5);
                write_reg(CFG_BASE_ADDR, (pick == 0) ? 32'h0 :
                                         (pick == 1) ? 32'hFFFF_FFFF : $urandom);
                for (k = 0; k < 161; k++) begin
                    if (k == 80 || $urandom_range(63) == 0)
                        drain_results();
                    n           = pool_slots();
                    r.free_addr = $urandom;
                    r.start_pos = CNT_W'($urandom_range(127));
                    pick        = $urandom_range(99);
                    if (pick < 40) begin
                        r.cmd = CMD_ALLOC;
                    end else if (pick < 75) begin
                        r.cmd = CMD_FREE;
                        lim   = (n == 0 || $urandom_range(7) == 0) ? 63 : n - 1;
                        j     = $urandom_range(lim);
                        repeat (6) if (!use_map[j]) j = $urandom_range(lim);
                        if ($urandom_range(9) > 1)
                            r.free_addr = slice_addr(j) + (($urandom_range(9) == 0) ? 1 : 0);
                    end else if (pick < 97) begin
                        r.cmd = CMD_SCAN;
                        if (n > 0 && $urandom_range(9) > 1)
                            r.start_pos = CNT_W'($urandom_range(n - 1));
                    end else begin
                        r.cmd = CMD_UNUSED;
                    end
                    send_req(r, 1'b0, '0);
                end
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d allocate, %0d free, %0d scan, %0d undefined requests, %0d reg writes",
                 alloc_reqs, free_reqs, scan_reqs, odd_reqs, reg_writes);
        $display("Checked %0d results, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("bitmap_slice_allocator_top test passed");
        end else begin
            $display("bitmap_slice_allocator_top test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", results_due.size());
        $display("bitmap_slice_allocator_top test failed");
        $finish;
    end

endmodule

// ===== bitmap_slice_allocator_top.f =====
rtl/bsa_pkg.sv
rtl/bsa_ctrl.sv
rtl/bsa_dp.sv
rtl/bitmap_slice_allocator_top.sv
test/bitmap_slice_allocator_top_tb.sv
